@@ rtl/dibp_pkg.sv @@
// Shared types, constants and helper functions for the dictionary index bit packer.
package dibp_pkg;

  localparam int DICT_DEPTH_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int SLOT_W      = 4;
  localparam int CODE_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int SEL_W       = 2;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int CWIDTH_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_WIDTH_SEL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DICT_COUNT     = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  localparam logic [SEL_W-1:0] SEL_1BIT = 2'd0;
  localparam logic [SEL_W-1:0] SEL_2BIT = 2'd1;
  localparam logic [SEL_W-1:0] SEL_4BIT = 2'd2;

  localparam logic [SEL_W-1:0]   CODE_WIDTH_SEL_RST = SEL_4BIT;
  localparam logic [COUNT_W-1:0] DICT_COUNT_RST     = 5'd16;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] index;
  } match_t;

  typedef struct packed {
    logic advance;
    logic encode;
    logic last;
  } pack_ctl_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] packed_byte;
    logic              not_found;
    logic              run_end;
  } result_t;

  // selector 3 falls back to 4-bit codes
  function automatic logic [CWIDTH_W-1:0] code_width(input logic [SEL_W-1:0] sel);
    logic [CWIDTH_W-1:0] w;
    case (sel)
      SEL_1BIT: w = 3'd1;
      SEL_2BIT: w = 3'd2;
      default:  w = 3'd4;
    endcase
    return w;
  endfunction

  function automatic logic [CODE_W-1:0] code_mask(input logic [SEL_W-1:0] sel);
    logic [CODE_W-1:0] m;
    case (sel)
      SEL_1BIT: m = 4'b0001;
      SEL_2BIT: m = 4'b0011;
      default:  m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/dibp_if.sv @@
// Valid/ready stream interfaces for the input items and the result items.
interface dibp_in_if #(
  parameter int VALUE_WIDTH = dibp_pkg::VALUE_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [dibp_pkg::SLOT_W-1:0] entry_index;
  logic [VALUE_WIDTH-1:0]      value_bits;
  logic                        last_value;

  modport source (output valid, command, entry_index, value_bits, last_value, input ready);
  modport sink   (input valid, command, entry_index, value_bits, last_value, output ready);
endinterface

interface dibp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        byte_valid;
  logic [dibp_pkg::BYTE_W-1:0] packed_byte;
  logic                        not_found;
  logic                        run_end;

  modport source (output valid, byte_valid, packed_byte, not_found, run_end, input ready);
  modport sink   (input valid, byte_valid, packed_byte, not_found, run_end, output ready);
endinterface

@@ rtl/dibp_dict.sv @@
// Dictionary storage with a parallel equality search and lowest-slot priority pick.
module dibp_dict #(
  parameter int DICT_DEPTH  = dibp_pkg::DICT_DEPTH_DEF,
  parameter int VALUE_WIDTH = dibp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [dibp_pkg::SLOT_W-1:0]   wr_index,
  input  logic [VALUE_WIDTH-1:0]        wr_data,
  input  logic [VALUE_WIDTH-1:0]        cmp_value,
  input  logic [dibp_pkg::COUNT_W-1:0]  dict_count,
  output dibp_pkg::match_t              match
);

  localparam int IDX_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam logic [dibp_pkg::SLOT_W:0]    DEPTH_SLOT  = (dibp_pkg::SLOT_W+1)'(DICT_DEPTH);
  localparam logic [dibp_pkg::COUNT_W-1:0] DEPTH_COUNT = dibp_pkg::COUNT_W'(DICT_DEPTH);

  logic [VALUE_WIDTH-1:0]       dictionary [DICT_DEPTH];
  logic [dibp_pkg::COUNT_W-1:0] search_count;
  logic [DICT_DEPTH-1:0]        hit;

  // out-of-range slots are dropped
  always_ff @(posedge clk) begin
    if (we && ({1'b0, wr_index} < DEPTH_SLOT)) begin
      dictionary[wr_index[IDX_W-1:0]] <= wr_data;
    end
  end

  assign search_count = (dict_count > DEPTH_COUNT) ? DEPTH_COUNT : dict_count;

  always_comb begin
    for (int i = 0; i < DICT_DEPTH; i++) begin
      hit[i] = (dictionary[i] == cmp_value) &&
               (dibp_pkg::COUNT_W'(i) < search_count);
    end
  end

  always_comb begin
    match.found = 1'b0;
    match.index = '0;
    for (int i = DICT_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match.found = 1'b1;
        match.index = dibp_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

@@ rtl/dibp_pack.sv @@
// Code selection and byte packer: accumulator, fill count and previous code.
module dibp_pack (
  input  logic                         clk,
  input  logic                         rst,
  input  dibp_pkg::pack_ctl_t          ctl,
  input  dibp_pkg::match_t             match,
  input  logic [dibp_pkg::SEL_W-1:0]   code_width_sel,
  output dibp_pkg::result_t            result
);

  localparam int ACC_W = dibp_pkg::BYTE_W + dibp_pkg::CODE_W;

  logic [dibp_pkg::BYTE_W-1:0]   byte_accumulator;
  logic [dibp_pkg::BYTE_W-1:0]   byte_accumulator_next;
  logic [3:0]                    bits_filled;
  logic [3:0]                    bits_filled_next;
  logic [dibp_pkg::CODE_W-1:0]   previous_code;
  logic [dibp_pkg::CODE_W-1:0]   previous_code_next;

  logic [dibp_pkg::CWIDTH_W-1:0] w;
  logic [dibp_pkg::CODE_W-1:0]   code;
  logic [ACC_W-1:0]              acc;
  logic [ACC_W-1:0]              flushed;
  logic [3:0]                    filled;
  logic [3:0]                    flush_shift;

  assign w      = dibp_pkg::code_width(code_width_sel);
  assign code   = (match.found ? match.index : previous_code) &
                  dibp_pkg::code_mask(code_width_sel);
  assign acc    = ({{dibp_pkg::CODE_W{1'b0}}, byte_accumulator} << w) |
                  {{dibp_pkg::BYTE_W{1'b0}}, code};
  assign filled = bits_filled + {1'b0, w};
  // left-align a partial byte; only used while filled is below 8
  assign flush_shift = 4'd8 - filled;
  assign flushed     = acc << flush_shift;

  always_comb begin
    result                = '0;
    byte_accumulator_next = byte_accumulator;
    bits_filled_next      = bits_filled;
    previous_code_next    = previous_code;
    if (ctl.encode) begin
      if (match.found) begin
        previous_code_next = match.index;
      end
      if (filled >= 4'd8) begin
        result.byte_valid     = 1'b1;
        result.packed_byte    = acc[dibp_pkg::BYTE_W-1:0];
        byte_accumulator_next = '0;
        bits_filled_next      = '0;
      end else if (ctl.last) begin
        result.byte_valid     = 1'b1;
        result.packed_byte    = flushed[dibp_pkg::BYTE_W-1:0];
        byte_accumulator_next = '0;
        bits_filled_next      = '0;
      end else begin
        byte_accumulator_next = acc[dibp_pkg::BYTE_W-1:0];
        bits_filled_next      = filled;
      end
      result.not_found = !match.found;
      if (ctl.last) begin
        result.run_end     = 1'b1;
        previous_code_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_accumulator <= '0;
      bits_filled      <= '0;
      previous_code    <= '0;
    end else if (ctl.advance) begin
      byte_accumulator <= byte_accumulator_next;
      bits_filled      <= bits_filled_next;
      previous_code    <= previous_code_next;
    end
  end

endmodule

@@ rtl/dictionary_index_bit_packer.sv @@
// Top level of the dictionary index bit packer: input stage, config, result register.
//
//   channel | dir | handshake     | payload
//   din     | in  | valid/ready   | command, entry_index, value_bits, last_value
//   dout    | out | valid/ready   | byte_valid, packed_byte, not_found, run_end
//   cfg     | in  | cfg_we only   | cfg_index, cfg_wdata
//
// One item per cycle unless dout stalls; items pass the input and result registers.
// The critical path is the 16-way value compare feeding the priority pick and packer.
// Synchronous active-high reset clears valids, config and packer state; the dictionary
// holds whatever was last loaded. A stalled result holds in the output register while
// the input stage still takes one more transaction.
module dictionary_index_bit_packer #(
  parameter int DICT_DEPTH  = dibp_pkg::DICT_DEPTH_DEF,
  parameter int VALUE_WIDTH = dibp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  dibp_in_if.sink                           din,
  dibp_out_if.source                        dout,
  input  logic                              cfg_we,
  input  logic [dibp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dibp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [dibp_pkg::SEL_W-1:0]   code_width_sel;
  logic [dibp_pkg::COUNT_W-1:0] dict_count;

  logic                        s1_valid;
  logic                        s1_command;
  logic [dibp_pkg::SLOT_W-1:0] s1_entry_index;
  logic [VALUE_WIDTH-1:0]      s1_value_bits;
  logic                        s1_last_value;

  logic                        out_valid;
  dibp_pkg::result_t           out_result;

  logic                        advance;
  dibp_pkg::match_t            match;
  dibp_pkg::pack_ctl_t         ctl;
  dibp_pkg::result_t           result;

  assign advance   = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_width_sel <= dibp_pkg::CODE_WIDTH_SEL_RST;
      dict_count     <= dibp_pkg::DICT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dibp_pkg::CFG_CODE_WIDTH_SEL: code_width_sel <= cfg_wdata[dibp_pkg::SEL_W-1:0];
        dibp_pkg::CFG_DICT_COUNT:     dict_count     <= cfg_wdata[dibp_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_command     <= din.command;
      s1_entry_index <= din.entry_index;
      s1_value_bits  <= din.value_bits;
      s1_last_value  <= din.last_value;
    end
  end

  dibp_dict #(
    .DICT_DEPTH  (DICT_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dict (
    .clk        (clk),
    .we         (advance && (s1_command == dibp_pkg::CMD_LOAD)),
    .wr_index   (s1_entry_index),
    .wr_data    (s1_value_bits),
    .cmp_value  (s1_value_bits),
    .dict_count (dict_count),
    .match      (match)
  );

  assign ctl.advance = advance;
  assign ctl.encode  = (s1_command == dibp_pkg::CMD_ENCODE);
  assign ctl.last    = s1_last_value;

  dibp_pack u_pack (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .match          (match),
    .code_width_sel (code_width_sel),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.byte_valid  = out_result.byte_valid;
  assign dout.packed_byte = out_result.packed_byte;
  assign dout.not_found   = out_result.not_found;
  assign dout.run_end     = out_result.run_end;

  // a column end always flushes or completes a byte
  a_run_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.run_end |-> out_result.byte_valid)
    else $error("run_end without byte_valid");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.byte_valid |-> out_result.packed_byte == '0)
    else $error("packed_byte nonzero without byte_valid");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> s1_valid && out_valid && !dout.ready)
    else $error("input stalled while pipeline has room");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("valids not cleared by reset");

endmodule

@@ dv/tb_dictionary_index_bit_packer.sv @@
// Self-checking testbench for the dictionary index bit packer: random stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_dictionary_index_bit_packer;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int IDLE_LIMIT      = 2000;
  localparam int END_WAIT        = 4;

  // selector code the package leaves unnamed; the block treats it as 4-bit codes
  localparam logic [dibp_pkg::SEL_W-1:0] SEL_RESERVED = 2'd3;

  typedef struct packed {
    logic                                 command;
    logic [dibp_pkg::SLOT_W-1:0]          entry_index;
    logic [dibp_pkg::VALUE_WIDTH_DEF-1:0] value_bits;
    logic                                 last_value;
  } column_item_t;

  class packer_scoreboard;
    logic [dibp_pkg::VALUE_WIDTH_DEF-1:0] dict [dibp_pkg::DICT_DEPTH_DEF];
    logic [dibp_pkg::BYTE_W-1:0]          acc;
    int                                   bits;
    logic [dibp_pkg::CODE_W-1:0]          prev_code;
    logic [dibp_pkg::SEL_W-1:0]           width_sel;
    logic [dibp_pkg::COUNT_W-1:0]         count;
    dibp_pkg::result_t                    packed_q [$];
    int                                   errors;

    function new();
      foreach (dict[i]) dict[i] = '0;
      acc       = '0;
      bits      = 0;
      prev_code = '0;
      width_sel = dibp_pkg::CODE_WIDTH_SEL_RST;
      count     = dibp_pkg::DICT_COUNT_RST;
      errors    = 0;
    endfunction

    function void set_register(logic [dibp_pkg::CFG_INDEX_W-1:0] idx,
                               logic [dibp_pkg::CFG_DATA_W-1:0] data);
      if (idx == dibp_pkg::CFG_CODE_WIDTH_SEL) width_sel = data[dibp_pkg::SEL_W-1:0];
      else if (idx == dibp_pkg::CFG_DICT_COUNT) count = data[dibp_pkg::COUNT_W-1:0];
    endfunction

    function int searched();
      return (count > dibp_pkg::DICT_DEPTH_DEF) ? dibp_pkg::DICT_DEPTH_DEF : int'(count);
    endfunction

    // predicts the result of one accepted input transaction
    function void note_item(column_item_t it);
      dibp_pkg::result_t           r;
      int                          w;
      int                          n;
      int                          cmask;
      int                          filled;
      logic [dibp_pkg::CODE_W-1:0] code;
      logic [15:0]                 shifted;
      bit                          found;
      r = '0;
      if (it.command == dibp_pkg::CMD_LOAD) begin
        dict[it.entry_index] = it.value_bits;
      end else begin
        case (width_sel)
          dibp_pkg::SEL_1BIT: w = 1;
          dibp_pkg::SEL_2BIT: w = 2;
          default:            w = 4;
        endcase
        cmask = (1 << w) - 1;
        n     = searched();
        code  = prev_code;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!found && dict[i] == it.value_bits) begin
            code  = i[dibp_pkg::CODE_W-1:0];
            found = 1'b1;
          end
        end
        if (found) prev_code = code;
        code    = code & cmask[dibp_pkg::CODE_W-1:0];
        shifted = ({8'h00, acc} << w) | {12'h000, code};
        filled  = bits + w;
        if (filled >= 8) begin
          // older bits beyond the byte are dropped after a mid-byte width change
          r.byte_valid  = 1'b1;
          r.packed_byte = shifted[7:0];
          acc  = '0;
          bits = 0;
        end else if (it.last_value) begin
          shifted       = shifted << (8 - filled);
          r.byte_valid  = 1'b1;
          r.packed_byte = shifted[7:0];
          acc  = '0;
          bits = 0;
        end else begin
          acc  = shifted[7:0];
          bits = filled;
        end
        r.not_found = !found;
        if (it.last_value) begin
          r.run_end = 1'b1;
          acc       = '0;
          bits      = 0;
          prev_code = '0;
        end
      end
      packed_q = {packed_q, r};
    endfunction

    function void check_result(dibp_pkg::result_t got);
      dibp_pkg::result_t want;
      if (packed_q.size() == 0) begin
        $error("result with none outstanding: packed_byte actual %02h", got.packed_byte);
        errors++;
        return;
      end
      want = packed_q.pop_front();
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.packed_byte !== want.packed_byte) begin
        $error("packed_byte: expected %02h, actual %02h", want.packed_byte, got.packed_byte);
        errors++;
      end
      if (got.not_found !== want.not_found) begin
        $error("not_found: expected %0b, actual %0b", want.not_found, got.not_found);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0b, actual %0b", want.run_end, got.run_end);
        errors++;
      end
    endfunction

    function int pending();
      return packed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                             cfg_we;
  logic [dibp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dibp_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  bit                               no_idle;
  int                               idle_cycles;
  packer_scoreboard                 sb;

  dibp_in_if #(.VALUE_WIDTH(dibp_pkg::VALUE_WIDTH_DEF)) col_in ();
  dibp_out_if                                           byte_out ();

  dictionary_index_bit_packer #(
    .DICT_DEPTH  (dibp_pkg::DICT_DEPTH_DEF),
    .VALUE_WIDTH (dibp_pkg::VALUE_WIDTH_DEF)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .din       (col_in),
    .dout      (byte_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none at all in steady stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic send_item(input column_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      col_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    col_in.valid       <= 1'b1;
    col_in.command     <= it.command;
    col_in.entry_index <= it.entry_index;
    col_in.value_bits  <= it.value_bits;
    col_in.last_value  <= it.last_value;
    do @(posedge clk); while (!col_in.ready);
  endtask

  task automatic send_load(input int slot,
                           input logic [dibp_pkg::VALUE_WIDTH_DEF-1:0] value,
                           input logic last);
    send_item('{command: dibp_pkg::CMD_LOAD, entry_index: slot[dibp_pkg::SLOT_W-1:0],
                value_bits: value, last_value: last});
  endtask

  task automatic send_encode(input logic [dibp_pkg::VALUE_WIDTH_DEF-1:0] value,
                             input logic last);
    send_item('{command: dibp_pkg::CMD_ENCODE, entry_index: '0, value_bits: value,
                last_value: last});
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain();
    col_in.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_register(input logic [dibp_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [dibp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, data);
    @(posedge clk);
  endtask

  function automatic column_item_t random_item();
    column_item_t it;
    int           r;
    int           n;
    r = $urandom_range(0, 99);
    n = sb.searched();
    it.command     = dibp_pkg::CMD_ENCODE;
    it.entry_index = dibp_pkg::SLOT_W'($urandom_range(0, dibp_pkg::DICT_DEPTH_DEF - 1));
    it.last_value  = ($urandom_range(0, 11) == 0);
    if (r < 10) begin
      it.command    = dibp_pkg::CMD_LOAD;
      it.last_value = 1'($urandom_range(0, 1));
      // some loads duplicate an existing entry so the lowest slot must win
      if ($urandom_range(0, 2) == 0)
        it.value_bits = sb.dict[$urandom_range(0, dibp_pkg::DICT_DEPTH_DEF - 1)];
      else
        it.value_bits = {$urandom, $urandom};
    end else if (r < 78 && n > 0) begin
      it.value_bits = sb.dict[$urandom_range(0, n - 1)];
    end else if (r < 86) begin
      it.value_bits = sb.dict[$urandom_range(0, dibp_pkg::DICT_DEPTH_DEF - 1)];
    end else begin
      it.value_bits = {$urandom, $urandom};
    end
    return it;
  endfunction

  // one process watches both channels so input notes always precede result checks
  always @(posedge clk) begin
    if (!rst) begin
      if (col_in.valid && col_in.ready)
        sb.note_item('{command: col_in.command, entry_index: col_in.entry_index,
                       value_bits: col_in.value_bits, last_value: col_in.last_value});
      if (byte_out.valid && byte_out.ready)
        sb.check_result('{byte_valid: byte_out.byte_valid, packed_byte: byte_out.packed_byte,
                          not_found: byte_out.not_found, run_end: byte_out.run_end});
      if ((col_in.valid && col_in.ready) || (byte_out.valid && byte_out.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("dictionary_index_bit_packer: mismatch");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    stall = 0;
    byte_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        byte_out.ready <= 1'b0;
        stall--;
      end else begin
        byte_out.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  initial begin
    logic [dibp_pkg::VALUE_WIDTH_DEF-1:0] pattern;
    logic [dibp_pkg::SEL_W-1:0]           sel;
    logic [dibp_pkg::COUNT_W-1:0]         cnt;
    sb          = new();
    no_idle     = 1'b0;
    idle_cycles = 0;
    col_in.valid       <= 1'b0;
    col_in.command     <= dibp_pkg::CMD_LOAD;
    col_in.entry_index <= '0;
    col_in.value_bits  <= '0;
    col_in.last_value  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= dibp_pkg::CFG_CODE_WIDTH_SEL;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill every slot first so no search ever touches an unloaded entry
    for (int i = 0; i < dibp_pkg::DICT_DEPTH_DEF; i++) begin
      case (i)
        0:       pattern = '0;
        1:       pattern = '1;
        2:       pattern = 64'h8000_0000_0000_0000;
        3:       pattern = 64'h0000_0000_0000_0001;
        4:       pattern = 64'hAAAA_AAAA_AAAA_AAAA;
        5:       pattern = 64'h5555_5555_5555_5555;
        9:       pattern = 64'h8000_0000_0000_0000;  // duplicate of slot 2
        default: pattern = {$urandom, $urandom};
      endcase
      // last_value on a load is ignored
      send_load(i, pattern, i == dibp_pkg::DICT_DEPTH_DEF - 1);
    end

    // reset config: 4-bit codes, all slots searched
    send_encode(sb.dict[15], 1'b0);
    send_encode(sb.dict[0], 1'b0);
    send_encode(sb.dict[2], 1'b0);
    send_encode(64'h0123_4567_89AB_CDEF, 1'b0);  // miss reuses the last code
    send_encode(sb.dict[1], 1'b1);               // partial byte flushed
    send_encode(64'h0123_4567_89AB_CDEF, 1'b1);  // miss right after the column ends
    send_encode(sb.dict[5], 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin sel = dibp_pkg::SEL_1BIT; cnt = 5'd1;  end
        1:       begin sel = dibp_pkg::SEL_2BIT; cnt = 5'd4;  end
        2:       begin sel = dibp_pkg::SEL_4BIT; cnt = 5'd16; end
        3:       begin sel = SEL_RESERVED;       cnt = 5'd31; end
        4:       begin sel = dibp_pkg::SEL_1BIT; cnt = 5'd0;  end
        5:       begin sel = dibp_pkg::SEL_2BIT; cnt = 5'd17; end
        6:       begin sel = dibp_pkg::SEL_4BIT; cnt = 5'd8;  end
        default: begin
          sel = dibp_pkg::SEL_W'($urandom_range(0, 3));
          cnt = dibp_pkg::COUNT_W'($urandom_range(0, 31));
        end
      endcase
      // a phase may end mid-byte, so the next width starts on leftover bits
      write_register(dibp_pkg::CFG_CODE_WIDTH_SEL,
                     {{(dibp_pkg::CFG_DATA_W - dibp_pkg::SEL_W){1'b0}}, sel});
      write_register(dibp_pkg::CFG_DICT_COUNT, cnt);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_item(random_item());
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("dictionary_index_bit_packer: match");
    else
      $display("dictionary_index_bit_packer: mismatch");
    $finish;
  end

endmodule
